@@ rtl/core/bpba_pkg.sv @@
// Package for the block pool bump allocator.
// Holds field widths, command and status codes, and the block alignment helper.
// No dependencies.
package bpba_pkg;

   localparam int unsigned NUM_BLOCKS_DEF  = 8;
   localparam int unsigned BLOCK_BYTES_DEF = 4096;

   localparam int unsigned SIZE_W     = 13;
   localparam int unsigned ADDR_W     = 15;
   localparam int unsigned COUNT_W    = 7;
   localparam int unsigned ALIGN_BITS = 6;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_SPACE = 2'd1,
      STATUS_BAD_FREE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   // Offset of a block's base address within its 64-byte line.
   function automatic logic [ALIGN_BITS-1:0] misalign(input int unsigned blk,
                                                      input int unsigned bytes);
      logic [63:0] prod;
      prod = 64'(blk) * 64'(bytes);
      return prod[ALIGN_BITS-1:0];
   endfunction

endpackage

@@ rtl/core/bpba_search.sv @@
// Round-robin search for a block with no live allocations that can take a request.
// Starts after the current block and ends with it; also gives the fresh end offset.
// Depends on bpba_pkg.
module bpba_search #(
   parameter int unsigned NUM_BLOCKS  = bpba_pkg::NUM_BLOCKS_DEF,
   parameter int unsigned BLOCK_BYTES = bpba_pkg::BLOCK_BYTES_DEF,
   localparam int unsigned IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1,
   localparam int unsigned OFS_W = $clog2(BLOCK_BYTES + 1)
) (
   input  logic [IDX_W-1:0]      cur_block,
   input  logic [NUM_BLOCKS-1:0] zero_flags,
   input  logic [OFS_W-1:0]      remain,
   output logic                  found,
   output logic [IDX_W-1:0]      found_block,
   output logic [OFS_W-1:0]      fresh_end
);

   localparam int unsigned AB = bpba_pkg::ALIGN_BITS;

   logic [AB-1:0]         mis_arr [NUM_BLOCKS];
   logic [OFS_W:0]        sum_arr [NUM_BLOCKS];
   logic [NUM_BLOCKS-1:0] cand;
   logic [IDX_W:0]        step_idx;
   logic [OFS_W:0]        sum_sel;

   for (genvar b = 0; b < NUM_BLOCKS; b++) begin : g_blk
      assign mis_arr[b] = bpba_pkg::misalign(b, BLOCK_BYTES);
      assign sum_arr[b] = (OFS_W+1)'(remain) + (OFS_W+1)'(mis_arr[b]);
      // A fresh block fits unless alignment drops the address below its base.
      assign cand[b] = zero_flags[b] &&
                       ((mis_arr[b] == '0) || (sum_arr[b] >= (OFS_W+1)'(64)));
   end

   always_comb begin
      found       = 1'b0;
      found_block = '0;
      step_idx    = '0;
      for (int k = NUM_BLOCKS; k >= 1; k--) begin
         step_idx = {1'b0, cur_block} + (IDX_W+1)'(k);
         if (step_idx >= (IDX_W+1)'(NUM_BLOCKS)) begin
            step_idx = step_idx - (IDX_W+1)'(NUM_BLOCKS);
         end
         if (cand[step_idx[IDX_W-1:0]]) begin
            found       = 1'b1;
            found_block = step_idx[IDX_W-1:0];
         end
      end
   end

   assign sum_sel   = sum_arr[found_block];
   assign fresh_end = OFS_W'({sum_sel[OFS_W:AB], AB'(0)} -
                             (OFS_W+1)'(mis_arr[found_block]));

endmodule

@@ rtl/core/block_pool_bump_allocator.sv @@
// Block pool bump allocator: per-block end offsets and live counts in memories.
// The memories are read at the edge that accepts a request beat; the response beat
// is valid after the execute state, when state and the response register are updated.
// A new request is taken only in the idle state; a waiting response beat stalls the update.
// Synchronous reset flags all counts as zero and all end offsets as the block size.
// Depends on bpba_pkg and bpba_search.
module block_pool_bump_allocator #(
   parameter int unsigned NUM_BLOCKS  = bpba_pkg::NUM_BLOCKS_DEF,
   parameter int unsigned BLOCK_BYTES = bpba_pkg::BLOCK_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // alloc_size [12:0], free_address [27:13], zero above
   input  logic        req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // address [14:0], zero above
   output logic [1:0]  rsp_tuser    // status
);

   localparam int unsigned SIZE_W  = bpba_pkg::SIZE_W;
   localparam int unsigned ADDR_W  = bpba_pkg::ADDR_W;
   localparam int unsigned COUNT_W = bpba_pkg::COUNT_W;
   localparam int unsigned AB      = bpba_pkg::ALIGN_BITS;
   localparam int unsigned IDX_W   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int unsigned OFS_W   = $clog2(BLOCK_BYTES + 1);
   localparam int unsigned AW_RAW  = $clog2(NUM_BLOCKS * BLOCK_BYTES + 1);
   localparam int unsigned AW      = (AW_RAW > ADDR_W) ? AW_RAW : ADDR_W;

   logic [OFS_W-1:0]   end_mem [NUM_BLOCKS];
   logic [COUNT_W-1:0] cnt_mem [NUM_BLOCKS];

   bpba_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]      cur_ff, cur_in;
   logic [NUM_BLOCKS-1:0] zero_ff, zero_in;
   logic [NUM_BLOCKS-1:0] end_vld_ff, end_vld_in;

   logic              cmd_ff;
   logic [SIZE_W-1:0] size_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic              oob_ff;
   logic [OFS_W-1:0]   end_rd_ff;
   logic [COUNT_W-1:0] cnt_rd_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   bpba_pkg::status_type rsp_status_ff, rsp_status_in;

   logic              accept;
   logic [SIZE_W-1:0] req_size;
   logic [ADDR_W-1:0] req_free;
   logic [AW-1:0]     free_blk;
   logic [IDX_W-1:0]  rd_idx;

   logic               exec_go;
   logic [OFS_W-1:0]   end_eff;
   logic [COUNT_W-1:0] cnt_eff;
   logic [AW-1:0]      size_ext;
   logic [AW-1:0]      base_cur;
   logic [AW-1:0]      carve_raw;
   logic [AW-1:0]      carve_al;
   logic               size_bad;
   logic               cur_fit;
   logic [OFS_W-1:0]   remain;
   logic               srch_found;
   logic [IDX_W-1:0]   srch_block;
   logic [OFS_W-1:0]   srch_end;

   logic               wr_en;
   logic               wr_end_en;
   logic [IDX_W-1:0]   wr_idx;
   logic [OFS_W-1:0]   wr_end;
   logic [COUNT_W-1:0] wr_cnt;

   assign req_size   = req_tdata[SIZE_W-1:0];
   assign req_free   = req_tdata[SIZE_W+ADDR_W-1:SIZE_W];
   assign req_tready = (state_ff == bpba_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rd_idx     = (req_tuser == bpba_pkg::CMD_FREE) ? free_blk[IDX_W-1:0] : cur_ff;

   // The block of a freed address is the number of boundaries b*BLOCK_BYTES (b = 1..NUM_BLOCKS) at or below it.
   always_comb begin
      free_blk = '0;
      for (int b = 1; b <= NUM_BLOCKS; b++) begin
         if (AW'(req_free) >= AW'(b * BLOCK_BYTES)) begin
            free_blk = AW'(b);
         end
      end
   end

   assign exec_go  = (state_ff == bpba_pkg::ST_EXEC) && (!rsp_valid_ff || rsp_tready);
   assign end_eff  = end_vld_ff[idx_ff] ? end_rd_ff : OFS_W'(BLOCK_BYTES);
   assign cnt_eff  = zero_ff[idx_ff] ? '0 : cnt_rd_ff;
   assign size_ext = AW'(size_ff);
   assign base_cur = AW'(idx_ff) * AW'(BLOCK_BYTES);
   assign carve_raw = base_cur + AW'(end_eff) - size_ext;
   assign carve_al  = {carve_raw[AW-1:AB], AB'(0)};
   assign size_bad  = (size_ff == '0) || (size_ext > AW'(BLOCK_BYTES));
   assign cur_fit   = (cnt_eff < bpba_pkg::COUNT_MAX) && (AW'(end_eff) >= size_ext) &&
                      (carve_al >= base_cur);
   assign remain    = OFS_W'(AW'(BLOCK_BYTES) - size_ext);

   bpba_search #(
      .NUM_BLOCKS  (NUM_BLOCKS),
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_search (
      .cur_block   (idx_ff),
      .zero_flags  (zero_ff),
      .remain      (remain),
      .found       (srch_found),
      .found_block (srch_block),
      .fresh_end   (srch_end)
   );

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      zero_in       = zero_ff;
      end_vld_in    = end_vld_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_end_en     = 1'b0;
      wr_idx        = idx_ff;
      wr_end        = end_eff;
      wr_cnt        = cnt_eff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         bpba_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = bpba_pkg::ST_EXEC;
            end
         end
         bpba_pkg::ST_EXEC: begin
            if (exec_go) begin
               state_in      = bpba_pkg::ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = '0;
               rsp_status_in = bpba_pkg::STATUS_OK;
               if (cmd_ff == bpba_pkg::CMD_ALLOC) begin
                  if (size_bad) begin
                     rsp_status_in = bpba_pkg::STATUS_NO_SPACE;
                  end else if (cur_fit) begin
                     wr_en       = 1'b1;
                     wr_end_en   = 1'b1;
                     wr_end      = OFS_W'(carve_al - base_cur);
                     wr_cnt      = cnt_eff + COUNT_W'(1);
                     rsp_addr_in = carve_al[ADDR_W-1:0];
                  end else if (srch_found) begin
                     wr_en       = 1'b1;
                     wr_end_en   = 1'b1;
                     wr_idx      = srch_block;
                     wr_end      = srch_end;
                     wr_cnt      = COUNT_W'(1);
                     cur_in      = srch_block;
                     rsp_addr_in = ADDR_W'(AW'(srch_block) * AW'(BLOCK_BYTES) +
                                           AW'(srch_end));
                  end else begin
                     rsp_status_in = bpba_pkg::STATUS_NO_SPACE;
                  end
                  if (wr_en) begin
                     zero_in[wr_idx]    = 1'b0;
                     end_vld_in[wr_idx] = 1'b1;
                  end
               end else begin
                  if (oob_ff || zero_ff[idx_ff]) begin
                     rsp_status_in = bpba_pkg::STATUS_BAD_FREE;
                  end else begin
                     wr_en           = 1'b1;
                     wr_cnt          = cnt_eff - COUNT_W'(1);
                     zero_in[idx_ff] = (cnt_eff == COUNT_W'(1));
                  end
               end
            end
         end
         default: begin
            state_in = bpba_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bpba_pkg::ST_IDLE;
         cur_ff       <= '0;
         zero_ff      <= '1;
         end_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         zero_ff      <= zero_in;
         end_vld_ff   <= end_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      if (accept) begin
         cmd_ff    <= req_tuser;
         size_ff   <= req_size;
         idx_ff    <= rd_idx;
         oob_ff    <= (req_tuser == bpba_pkg::CMD_FREE) && (free_blk >= AW'(NUM_BLOCKS));
         end_rd_ff <= end_mem[rd_idx];
         cnt_rd_ff <= cnt_mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cnt_mem[wr_idx] <= wr_cnt;
      end
      if (wr_end_en) begin
         end_mem[wr_idx] <= wr_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_addr_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule
